// ----- hw/rtl/ctq_pkg.sv -----
// ----------------------------------------------------------------------------
// ctq_pkg
// Shared constants, operation codes and control bundles for the ticketed
// completion queue.
// ----------------------------------------------------------------------------
package ctq_pkg;

  localparam int unsigned CapacityDef = 16;

  localparam int unsigned OpW    = 3;
  localparam int unsigned WordW  = 64;
  localparam int unsigned CountW = 5;

  // input item: operation, handoff, ticket, payload, padded to bytes
  localparam int unsigned InFieldsW = OpW + 3 * WordW;
  localparam int unsigned InDataW   = ((InFieldsW + 7) / 8) * 8;

  // result item: ok, ticket_out, popped_handoff, popped_payload,
  // queued_count, reservation_count, cancelled_flag, drained
  localparam int unsigned OutFieldsW = 1 + 3 * WordW + 2 * CountW + 2;
  localparam int unsigned OutDataW   = ((OutFieldsW + 7) / 8) * 8;

  typedef enum logic [OpW-1:0] {
    OP_RESERVE = 3'd0,
    OP_PUBLISH = 3'd1,
    OP_POP     = 3'd2,
    OP_RELEASE = 3'd3,
    OP_CANCEL  = 3'd4
  } op_e;

  typedef struct packed {
    logic alloc;
    logic publish;
    logic pop;
    logic release_req;
    logic cancel;
  } tbl_cmd_t;

  typedef struct packed {
    logic full;
    logic pub_match;
  } tbl_stat_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic clear;
  } ring_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } ring_stat_t;

endpackage

// ----- hw/rtl/ticketed_completion_queue.sv -----
// ----------------------------------------------------------------------------
// ticketed_completion_queue
// Ticket-based completion queue: reserve, publish, pop, release and cancel.
// ----------------------------------------------------------------------------
// Usage:
//   One operation item enters on the s_axis group, one result item leaves
//   on the m_axis group for every operation. Items are taken when tvalid and
//   tready are both high.
//   The result passes from the input register through one single-pass
//   update of table and ring into the result register. Throughput: one
//   item per cycle while m_axis_tready stays high; the ticket lookup is a
//   parallel compare across all table entries. The result register holds a
//   finished item while the receiver stalls; one further item waits in the
//   input register, after which s_axis_tready drops until m_axis_tready
//   returns.
//   Reset (rst_ni low) empties the table and the ring, clears the cancelled
//   flag and sets the next ticket to one. No clearing pass is needed:
//   per-entry valid bits live in flip-flops.
//   Cancel is sticky: afterwards reserve and publish always fail and pop
//   finds the ring empty, while release and cancel still answer ok.
// ----------------------------------------------------------------------------
module ticketed_completion_queue
  import ctq_pkg::*;
#(
  parameter int unsigned CAPACITY = CapacityDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // operation[2:0], handoff[66:3], ticket[130:67], payload[194:131]
  input  logic [InDataW-1:0]  s_axis_tdata,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // ok[0], ticket_out[64:1], popped_handoff[128:65], popped_payload[192:129],
  // queued_count[197:193], reservation_count[202:198], cancelled_flag[203],
  // drained[204]
  output logic [OutDataW-1:0] m_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready
);

  localparam int unsigned IdxW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  localparam logic [WordW-1:0] TicketMax = '1;

  // ---- input register ----
  logic             in_v_q, in_v_d;
  logic [OpW-1:0]   op_q;
  logic [WordW-1:0] hid_q, tk_q, pl_q;

  // ---- result register ----
  logic                out_v_q, out_v_d;
  logic [OutDataW-1:0] out_q;

  // ---- architectural state kept here ----
  logic [WordW-1:0] next_tk_q, next_tk_d;
  logic             canc_q, canc_d;

  logic s_acc, advance;

  // an item moves out of the input register whenever the result slot is
  // free or being emptied this cycle
  assign advance       = in_v_q && (!out_v_q || m_axis_tready);
  assign s_axis_tready = !in_v_q || advance;
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign in_v_d        = s_acc || (in_v_q && !advance);
  assign out_v_d       = advance || (out_v_q && !m_axis_tready);

  // ---- sub-blocks ----
  tbl_cmd_t         tcmd;
  tbl_stat_t        tstat;
  logic [IdxW-1:0]  match_idx;
  logic [CntW-1:0]  res_cnt_d;

  ring_cmd_t        rcmd;
  ring_stat_t       rstat;
  logic [IdxW-1:0]  head_idx;
  logic [WordW-1:0] head_hid, head_pl;
  logic [CntW-1:0]  q_cnt_d;

  ctq_table #(
    .CAPACITY (CAPACITY),
    .IDX_W    (IdxW),
    .CNT_W    (CntW)
  ) u_table (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (tcmd),
    .handoff_i    (hid_q),
    .ticket_i     (tk_q),
    .new_ticket_i (next_tk_q),
    .pop_idx_i    (head_idx),
    .stat_o       (tstat),
    .match_idx_o  (match_idx),
    .res_cnt_d_o  (res_cnt_d)
  );

  ctq_ring #(
    .CAPACITY (CAPACITY),
    .IDX_W    (IdxW),
    .CNT_W    (CntW)
  ) u_ring (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (rcmd),
    .push_idx_i     (match_idx),
    .push_handoff_i (hid_q),
    .push_payload_i (pl_q),
    .stat_o         (rstat),
    .head_idx_o     (head_idx),
    .head_handoff_o (head_hid),
    .head_payload_o (head_pl),
    .count_d_o      (q_cnt_d)
  );

  // ---- operation decode ----
  logic             ok;
  logic [WordW-1:0] tk_out, p_hid, p_pl;
  logic [CountW-1:0] q_cnt_o, r_cnt_o;
  logic             drained;

  always_comb begin
    tcmd      = '0;
    rcmd      = '0;
    ok        = 1'b0;
    tk_out    = '0;
    p_hid     = '0;
    p_pl      = '0;
    next_tk_d = next_tk_q;
    canc_d    = canc_q;
    if (advance) begin
      unique case (op_e'(op_q))
        OP_RESERVE: begin
          if (!canc_q && (hid_q != '0) && !tstat.full && (next_tk_q != TicketMax)) begin
            tcmd.alloc = 1'b1;
            ok         = 1'b1;
            tk_out     = next_tk_q;
            next_tk_d  = next_tk_q + WordW'(1);
          end
        end
        OP_PUBLISH: begin
          // pub_match already covers known ticket, handoff equal, not queued
          if (!canc_q && (tk_q != '0) && tstat.pub_match && !rstat.full) begin
            tcmd.publish = 1'b1;
            rcmd.push    = 1'b1;
            ok           = 1'b1;
          end
        end
        OP_POP: begin
          if (!rstat.empty) begin
            tcmd.pop = 1'b1;
            rcmd.pop = 1'b1;
            ok       = 1'b1;
            p_hid    = head_hid;
            p_pl     = head_pl;
          end
        end
        OP_RELEASE: begin
          tcmd.release_req = (tk_q != '0);
          ok               = 1'b1;
        end
        OP_CANCEL: begin
          tcmd.cancel = 1'b1;
          rcmd.clear  = 1'b1;
          canc_d      = 1'b1;
          ok          = 1'b1;
        end
        default: begin
          ok = 1'b0;
        end
      endcase
    end
  end

  // counts after this step, cut to the reported field width
  assign q_cnt_o = CountW'(q_cnt_d);
  assign r_cnt_o = CountW'(res_cnt_d);
  assign drained = (q_cnt_d == '0) && (res_cnt_d == '0);

  // ---- registers ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q    <= 1'b0;
      out_v_q   <= 1'b0;
      next_tk_q <= WordW'(1);
      canc_q    <= 1'b0;
    end else begin
      in_v_q    <= in_v_d;
      out_v_q   <= out_v_d;
      next_tk_q <= next_tk_d;
      canc_q    <= canc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      op_q  <= s_axis_tdata[OpW-1:0];
      hid_q <= s_axis_tdata[OpW +: WordW];
      tk_q  <= s_axis_tdata[OpW + WordW +: WordW];
      pl_q  <= s_axis_tdata[OpW + 2 * WordW +: WordW];
    end
    if (advance) begin
      out_q <= OutDataW'({drained, canc_d, r_cnt_o, q_cnt_o, p_pl, p_hid, tk_out, ok});
    end
  end

  assign m_axis_tdata  = out_q;
  assign m_axis_tvalid = out_v_q;

endmodule

// ----- hw/rtl/ctq_table.sv -----
// ----------------------------------------------------------------------------
// ctq_table
// Reservation table: per-entry ticket/handoff storage, parallel ticket match,
// lowest-free-slot allocation and live reservation count.
// ----------------------------------------------------------------------------
module ctq_table
  import ctq_pkg::*;
#(
  parameter int unsigned CAPACITY = CapacityDef,
  parameter int unsigned IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  parameter int unsigned CNT_W    = $clog2(CAPACITY + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  tbl_cmd_t         cmd_i,
  input  logic [WordW-1:0] handoff_i,
  input  logic [WordW-1:0] ticket_i,
  input  logic [WordW-1:0] new_ticket_i,
  input  logic [IDX_W-1:0] pop_idx_i,
  output tbl_stat_t        stat_o,
  output logic [IDX_W-1:0] match_idx_o,
  output logic [CNT_W-1:0] res_cnt_d_o
);

  logic [CAPACITY-1:0] valid_q, valid_d;
  logic [CAPACITY-1:0] queued_q, queued_d;
  logic [CAPACITY-1:0] pending_q, pending_d;
  logic [WordW-1:0]    ticket_q  [CAPACITY];
  logic [WordW-1:0]    handoff_q [CAPACITY];
  logic [CNT_W-1:0]    cnt_q, cnt_d;

  logic [CAPACITY-1:0] match;
  logic [CAPACITY-1:0] pub_hit;
  logic [IDX_W-1:0]    free_idx;
  logic                has_free;
  logic                rel_free;
  logic                pop_free;

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      match[i]   = valid_q[i] && (ticket_q[i] == ticket_i);
      pub_hit[i] = match[i] && (handoff_q[i] == handoff_i) && !queued_q[i];
    end
  end

  // lowest free slot
  always_comb begin
    free_idx = '0;
    has_free = 1'b0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_idx = IDX_W'(i);
        has_free = 1'b1;
      end
    end
  end

  // tickets are unique, so at most one match bit is set
  always_comb begin
    match_idx_o = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (match[i]) begin
        match_idx_o = match_idx_o | IDX_W'(i);
      end
    end
  end

  assign rel_free = |(match & ~queued_q);
  assign pop_free = pending_q[pop_idx_i];

  assign stat_o.full      = !has_free;
  assign stat_o.pub_match = |pub_hit;

  always_comb begin
    valid_d   = valid_q;
    queued_d  = queued_q;
    pending_d = pending_q;
    cnt_d     = cnt_q;
    if (cmd_i.cancel) begin
      valid_d   = '0;
      queued_d  = '0;
      pending_d = '0;
      cnt_d     = '0;
    end else if (cmd_i.alloc) begin
      valid_d[free_idx]   = 1'b1;
      queued_d[free_idx]  = 1'b0;
      pending_d[free_idx] = 1'b0;
      cnt_d               = cnt_q + CNT_W'(1);
    end else if (cmd_i.publish) begin
      queued_d = queued_q | pub_hit;
    end else if (cmd_i.pop) begin
      queued_d[pop_idx_i] = 1'b0;
      if (pop_free) begin
        valid_d[pop_idx_i]   = 1'b0;
        pending_d[pop_idx_i] = 1'b0;
        cnt_d                = cnt_q - CNT_W'(1);
      end
    end else if (cmd_i.release_req) begin
      for (int i = 0; i < CAPACITY; i++) begin
        if (match[i]) begin
          if (queued_q[i]) begin
            pending_d[i] = 1'b1;
          end else begin
            valid_d[i]   = 1'b0;
            pending_d[i] = 1'b0;
          end
        end
      end
      if (rel_free) begin
        cnt_d = cnt_q - CNT_W'(1);
      end
    end
  end

  assign res_cnt_d_o = cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= '0;
      queued_q  <= '0;
      pending_q <= '0;
      cnt_q     <= '0;
    end else begin
      valid_q   <= valid_d;
      queued_q  <= queued_d;
      pending_q <= pending_d;
      cnt_q     <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.alloc && !cmd_i.cancel) begin
      ticket_q[free_idx]  <= new_ticket_i;
      handoff_q[free_idx] <= handoff_i;
    end
  end

endmodule

// ----- hw/rtl/ctq_ring.sv -----
// ----------------------------------------------------------------------------
// ctq_ring
// Completion ring: entry index, handoff and payload per slot, head/tail
// pointers and fill count.
// ----------------------------------------------------------------------------
module ctq_ring
  import ctq_pkg::*;
#(
  parameter int unsigned CAPACITY = CapacityDef,
  parameter int unsigned IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  parameter int unsigned CNT_W    = $clog2(CAPACITY + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ring_cmd_t        cmd_i,
  input  logic [IDX_W-1:0] push_idx_i,
  input  logic [WordW-1:0] push_handoff_i,
  input  logic [WordW-1:0] push_payload_i,
  output ring_stat_t       stat_o,
  output logic [IDX_W-1:0] head_idx_o,
  output logic [WordW-1:0] head_handoff_o,
  output logic [WordW-1:0] head_payload_o,
  output logic [CNT_W-1:0] count_d_o
);

  localparam logic [IDX_W-1:0] LastSlot = IDX_W'(CAPACITY - 1);
  localparam logic [CNT_W-1:0] FullCnt  = CNT_W'(CAPACITY);

  logic [IDX_W-1:0] idx_q     [CAPACITY];
  logic [WordW-1:0] handoff_q [CAPACITY];
  logic [WordW-1:0] payload_q [CAPACITY];

  logic [IDX_W-1:0] head_q, head_d;
  logic [IDX_W-1:0] tail_q, tail_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  assign stat_o.full  = (cnt_q == FullCnt);
  assign stat_o.empty = (cnt_q == '0);

  assign head_idx_o     = idx_q[head_q];
  assign head_handoff_o = handoff_q[head_q];
  assign head_payload_o = payload_q[head_q];

  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    cnt_d  = cnt_q;
    if (cmd_i.clear) begin
      head_d = '0;
      tail_d = '0;
      cnt_d  = '0;
    end else if (cmd_i.push) begin
      tail_d = (tail_q == LastSlot) ? '0 : tail_q + IDX_W'(1);
      cnt_d  = cnt_q + CNT_W'(1);
    end else if (cmd_i.pop) begin
      head_d = (head_q == LastSlot) ? '0 : head_q + IDX_W'(1);
      cnt_d  = cnt_q - CNT_W'(1);
    end
  end

  assign count_d_o = cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      cnt_q  <= '0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push && !cmd_i.clear) begin
      idx_q[tail_q]     <= push_idx_i;
      handoff_q[tail_q] <= push_handoff_i;
      payload_q[tail_q] <= push_payload_i;
    end
  end

endmodule
